// ===== src/svk_pse_pkg.sv =====
// ---------------------------------------------------------------------------
// svk_pse_pkg
// shared types, register indexes and saturation helper for the principal
// stress and energy pipeline
// ---------------------------------------------------------------------------
package svk_pse_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_DIMENSIONS  = 2'd0;
   localparam logic [1:0] CSR_CLAMP_FLOOR = 2'd1;
   localparam logic [1:0] CSR_SHEAR_MOD   = 2'd2;
   localparam logic [1:0] CSR_LAME_LAMBDA = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // reset values
   localparam logic [1:0]         DIMENSIONS_RESET  = 2'd3;
   localparam logic [16:0]        CLAMP_FLOOR_RESET = 17'd37837;
   localparam logic [30:0]        SHEAR_MOD_RESET   = 31'd65536;
   localparam logic signed [31:0] LAME_LAMBDA_RESET = 32'sd65536;

   localparam logic [1:0] DIMENSIONS_PLANAR = 2'd2;

   // one in q16.16
   localparam logic signed [63:0] Q_ONE = 64'sd65536;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   localparam int AXES = 3;

   typedef struct packed {
      logic                planar;
      logic [16:0]         clamp_floor;
      logic [30:0]         mu;
      logic signed [31:0]  lambda;
   } cfg_type;

   // clamped stretches and green strain terms
   typedef struct {
      logic [30:0]         s [AXES];
      logic signed [31:0]  g [AXES];
   } strain_beat_type;

   // stretches, per-axis stress factor, trace square and squared-strain sum
   typedef struct {
      logic [30:0]         s [AXES];
      logic signed [31:0]  u [AXES];
      logic signed [31:0]  q;
      logic signed [31:0]  p;
   } mix_beat_type;

   typedef struct {
      logic signed [31:0]  stress [AXES];
      logic signed [31:0]  energy;
   } result_beat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = WORD_MAX;
      end else if (v < -64'sd2147483648) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== src/svk_pse_strain.sv =====
// ---------------------------------------------------------------------------
// svk_pse_strain
// stages 1 to 3: floor clamp, stretch squaring, strain with saturation
// ---------------------------------------------------------------------------
module svk_pse_strain (
   input  logic                            clock,
   input  logic                            reset,
   input  svk_pse_pkg::cfg_type            cfg,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  logic signed [31:0]              in_stretch [svk_pse_pkg::AXES],
   output logic                            out_valid,
   input  logic                            out_stall,
   output svk_pse_pkg::strain_beat_type    out_beat
);

   logic [2:0] v_ff;
   logic [2:0] free;

   logic [30:0]        s1_ff  [svk_pse_pkg::AXES];
   logic [30:0]        s1_in  [svk_pse_pkg::AXES];
   logic [30:0]        s2_ff  [svk_pse_pkg::AXES];
   logic [61:0]        sq2_ff [svk_pse_pkg::AXES];
   logic [61:0]        sq2_in [svk_pse_pkg::AXES];
   svk_pse_pkg::strain_beat_type beat3_ff;
   svk_pse_pkg::strain_beat_type beat3_in;

   logic signed [31:0] floor_s;

   always_comb begin
      free[2] = !v_ff[2] || !out_stall;
      free[1] = !v_ff[1] || free[2];
      free[0] = !v_ff[0] || free[1];
   end

   assign in_stall  = !free[0];
   assign out_valid = v_ff[2];
   assign out_beat  = beat3_ff;
   assign floor_s   = $signed({15'd0, cfg.clamp_floor});

   // clamp from below
   always_comb begin
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         if (in_stretch[i] < floor_s) begin
            s1_in[i] = {14'd0, cfg.clamp_floor};
         end else begin
            s1_in[i] = in_stretch[i][30:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         sq2_in[i] = s1_ff[i] * s1_ff[i];
      end
   end

   // g = s*s - 1, zero on the unused axis in planar mode
   always_comb begin
      logic signed [63:0] diff;
      diff = '0;
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         diff = $signed({18'd0, sq2_ff[i][61:16]}) - svk_pse_pkg::Q_ONE;
         beat3_in.s[i] = s2_ff[i];
         if (cfg.planar && i == svk_pse_pkg::AXES - 1) begin
            beat3_in.g[i] = '0;
         end else begin
            beat3_in.g[i] = svk_pse_pkg::sat32(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (free[0]) v_ff[0] <= in_valid;
         if (free[1]) v_ff[1] <= v_ff[0];
         if (free[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (free[0] && in_valid) begin
         s1_ff <= s1_in;
      end
      if (free[1] && v_ff[0]) begin
         s2_ff  <= s1_ff;
         sq2_ff <= sq2_in;
      end
      if (free[2] && v_ff[1]) begin
         beat3_ff <= beat3_in;
      end
   end

endmodule

// ===== src/svk_pse_mix.sv =====
// ---------------------------------------------------------------------------
// svk_pse_mix
// stages 4 to 6: trace, strain products, stress factor and energy terms
// ---------------------------------------------------------------------------
module svk_pse_mix (
   input  logic                            clock,
   input  logic                            reset,
   input  svk_pse_pkg::cfg_type            cfg,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  svk_pse_pkg::strain_beat_type    in_beat,
   output logic                            out_valid,
   input  logic                            out_stall,
   output svk_pse_pkg::mix_beat_type       out_beat
);

   logic [2:0] v_ff;
   logic [2:0] free;

   // stage 4
   logic [30:0]        s4_ff   [svk_pse_pkg::AXES];
   logic signed [31:0] tr4_ff;
   logic signed [31:0] tr4_in;
   logic signed [63:0] mg4_ff  [svk_pse_pkg::AXES];
   logic signed [63:0] mg4_in  [svk_pse_pkg::AXES];
   logic signed [63:0] gg4_ff  [svk_pse_pkg::AXES];
   logic signed [63:0] gg4_in  [svk_pse_pkg::AXES];
   // stage 5
   logic [30:0]        s5_ff   [svk_pse_pkg::AXES];
   logic signed [63:0] lt5_ff;
   logic signed [63:0] lt5_in;
   logic signed [63:0] tt5_ff;
   logic signed [63:0] tt5_in;
   logic signed [47:0] mgs5_ff [svk_pse_pkg::AXES];
   logic signed [47:0] mgs5_in [svk_pse_pkg::AXES];
   logic signed [31:0] p5_ff;
   logic signed [31:0] p5_in;
   // stage 6
   svk_pse_pkg::mix_beat_type beat6_ff;
   svk_pse_pkg::mix_beat_type beat6_in;

   logic signed [31:0] mu_s;

   always_comb begin
      free[2] = !v_ff[2] || !out_stall;
      free[1] = !v_ff[1] || free[2];
      free[0] = !v_ff[0] || free[1];
   end

   assign in_stall  = !free[0];
   assign out_valid = v_ff[2];
   assign out_beat  = beat6_ff;
   assign mu_s      = $signed({1'b0, cfg.mu});

   always_comb begin
      logic signed [63:0] sum;
      sum = 64'(in_beat.g[0]) + 64'(in_beat.g[1]) + 64'(in_beat.g[2]);
      tr4_in = svk_pse_pkg::sat32(sum);
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         mg4_in[i] = 64'(mu_s) * 64'(in_beat.g[i]);
         gg4_in[i] = 64'(in_beat.g[i]) * 64'(in_beat.g[i]);
      end
   end

   always_comb begin
      logic signed [63:0] psum;
      lt5_in = 64'(cfg.lambda) * 64'(tr4_ff);
      tt5_in = 64'(tr4_ff) * 64'(tr4_ff);
      psum   = '0;
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         mgs5_in[i] = 48'(mg4_ff[i] >>> 16);
         psum       = psum + 64'(svk_pse_pkg::sat32(gg4_ff[i] >>> 16));
      end
      p5_in = svk_pse_pkg::sat32(psum);
   end

   always_comb begin
      logic signed [63:0] h;
      h = lt5_ff >>> 17;
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         beat6_in.s[i] = s5_ff[i];
         beat6_in.u[i] = svk_pse_pkg::sat32(64'(mgs5_ff[i]) + h);
      end
      beat6_in.q = svk_pse_pkg::sat32(tt5_ff >>> 16);
      beat6_in.p = p5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (free[0]) v_ff[0] <= in_valid;
         if (free[1]) v_ff[1] <= v_ff[0];
         if (free[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (free[0] && in_valid) begin
         s4_ff  <= in_beat.s;
         tr4_ff <= tr4_in;
         mg4_ff <= mg4_in;
         gg4_ff <= gg4_in;
      end
      if (free[1] && v_ff[0]) begin
         s5_ff   <= s4_ff;
         lt5_ff  <= lt5_in;
         tt5_ff  <= tt5_in;
         mgs5_ff <= mgs5_in;
         p5_ff   <= p5_in;
      end
      if (free[2] && v_ff[1]) begin
         beat6_ff <= beat6_in;
      end
   end

endmodule

// ===== src/svk_pse_out.sv =====
// ---------------------------------------------------------------------------
// svk_pse_out
// stages 7 and 8: stress and energy products, final saturation, output beat
// ---------------------------------------------------------------------------
module svk_pse_out (
   input  logic                            clock,
   input  logic                            reset,
   input  svk_pse_pkg::cfg_type            cfg,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  svk_pse_pkg::mix_beat_type       in_beat,
   output logic                            out_valid,
   input  logic                            out_stall,
   output svk_pse_pkg::result_beat_type    out_beat
);

   logic [1:0] v_ff;
   logic [1:0] free;

   logic signed [63:0] su7_ff [svk_pse_pkg::AXES];
   logic signed [63:0] su7_in [svk_pse_pkg::AXES];
   logic signed [63:0] lq7_ff;
   logic signed [63:0] lq7_in;
   logic signed [63:0] mp7_ff;
   logic signed [63:0] mp7_in;
   svk_pse_pkg::result_beat_type beat8_ff;
   svk_pse_pkg::result_beat_type beat8_in;

   logic signed [31:0] mu_s;

   always_comb begin
      free[1] = !v_ff[1] || !out_stall;
      free[0] = !v_ff[0] || free[1];
   end

   assign in_stall  = !free[0];
   assign out_valid = v_ff[1];
   assign out_beat  = beat8_ff;
   assign mu_s      = $signed({1'b0, cfg.mu});

   always_comb begin
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         su7_in[i] = 64'($signed({1'b0, in_beat.s[i]})) * 64'(in_beat.u[i]);
      end
      lq7_in = 64'(cfg.lambda) * 64'(in_beat.q);
      mp7_in = 64'(mu_s) * 64'(in_beat.p);
   end

   always_comb begin
      for (int i = 0; i < svk_pse_pkg::AXES; i++) begin
         if (cfg.planar && i == svk_pse_pkg::AXES - 1) begin
            beat8_in.stress[i] = '0;
         end else begin
            beat8_in.stress[i] = svk_pse_pkg::sat32(su7_ff[i] >>> 16);
         end
      end
      beat8_in.energy = svk_pse_pkg::sat32((lq7_ff >>> 19) + (mp7_ff >>> 18));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (free[0]) v_ff[0] <= in_valid;
         if (free[1]) v_ff[1] <= v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (free[0] && in_valid) begin
         su7_ff <= su7_in;
         lq7_ff <= lq7_in;
         mp7_ff <= mp7_in;
      end
      if (free[1] && v_ff[0]) begin
         beat8_ff <= beat8_in;
      end
   end

endmodule

// ===== src/svk_principal_stress_energy_unit.sv =====
// ---------------------------------------------------------------------------
// svk_principal_stress_energy_unit
// st venant-kirchhoff diagonal stress and strain energy from principal stretches
// ---------------------------------------------------------------------------
// One beat in per cycle, one result beat out per cycle while the result side
// does not stall. The pipeline depth is set by the chain of dependent
// multiplications (stretch squared, strain times modulus, trace times lambda,
// stretch times stress factor), each followed by a register, with shift and
// saturation stages in between. Every stage carries its own valid bit and
// holds when the stage after it is full and stalled, so a stall on the result
// side backs up one stage at a time and req_stall rises only once all eight
// stages hold a beat. Results saturate to signed q16.16. Registers are to be
// written through the csr port only while no beat is in flight; the block
// itself does not enforce this. Index 0 dimensions (2 = planar, else three
// axes), 1 clamp floor, 2 shear modulus, 3 lame lambda.
// ---------------------------------------------------------------------------
module svk_principal_stress_energy_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [31:0]                        req_stretch_x,
   input  logic signed [31:0]                        req_stretch_y,
   input  logic signed [31:0]                        req_stretch_z,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [31:0]                        rsp_stress_x,
   output logic signed [31:0]                        rsp_stress_y,
   output logic signed [31:0]                        rsp_stress_z,
   output logic signed [31:0]                        rsp_energy,
   // register write port
   input  logic                                      csr_write,
   input  logic [svk_pse_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [svk_pse_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   // configuration registers
   logic [1:0]         dimensions_ff;
   logic [16:0]        clamp_floor_ff;
   logic [30:0]        shear_mod_ff;
   logic signed [31:0] lame_lambda_ff;

   svk_pse_pkg::cfg_type cfg;

   // stage hand-off
   logic                            strain_valid;
   logic                            strain_stall;
   svk_pse_pkg::strain_beat_type    strain_beat;
   logic                            mix_valid;
   logic                            mix_stall;
   svk_pse_pkg::mix_beat_type       mix_beat;
   svk_pse_pkg::result_beat_type    result_beat;

   logic signed [31:0] stretch [svk_pse_pkg::AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         dimensions_ff  <= svk_pse_pkg::DIMENSIONS_RESET;
         clamp_floor_ff <= svk_pse_pkg::CLAMP_FLOOR_RESET;
         shear_mod_ff   <= svk_pse_pkg::SHEAR_MOD_RESET;
         lame_lambda_ff <= svk_pse_pkg::LAME_LAMBDA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            svk_pse_pkg::CSR_DIMENSIONS:  dimensions_ff  <= csr_data[1:0];
            svk_pse_pkg::CSR_CLAMP_FLOOR: clamp_floor_ff <= csr_data[16:0];
            svk_pse_pkg::CSR_SHEAR_MOD:   shear_mod_ff   <= csr_data[30:0];
            svk_pse_pkg::CSR_LAME_LAMBDA: lame_lambda_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // values 0, 1 and 3 all mean three axes
   always_comb begin
      cfg.planar      = (dimensions_ff == svk_pse_pkg::DIMENSIONS_PLANAR);
      cfg.clamp_floor = clamp_floor_ff;
      cfg.mu          = shear_mod_ff;
      cfg.lambda      = lame_lambda_ff;
   end

   assign stretch[0] = req_stretch_x;
   assign stretch[1] = req_stretch_y;
   assign stretch[2] = req_stretch_z;

   // stages 1-3: clamp, square, strain
   svk_pse_strain u_strain (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_stretch (stretch),
      .out_valid  (strain_valid),
      .out_stall  (strain_stall),
      .out_beat   (strain_beat)
   );

   // stages 4-6: trace, strain products, stress factor
   svk_pse_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (strain_valid),
      .in_stall  (strain_stall),
      .in_beat   (strain_beat),
      .out_valid (mix_valid),
      .out_stall (mix_stall),
      .out_beat  (mix_beat)
   );

   // stages 7-8: final products, output register
   svk_pse_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mix_valid),
      .in_stall  (mix_stall),
      .in_beat   (mix_beat),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_beat  (result_beat)
   );

   assign rsp_stress_x = result_beat.stress[0];
   assign rsp_stress_y = result_beat.stress[1];
   assign rsp_stress_z = result_beat.stress[2];
   assign rsp_energy   = result_beat.energy;

endmodule

// ===== src/svk_pse_checker.sv =====
// ---------------------------------------------------------------------------
// svk_pse_checker
// port-level checks on the stress and energy pipeline
// ---------------------------------------------------------------------------
module svk_pse_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic signed [31:0]                        req_stretch_x,
   input  logic signed [31:0]                        req_stretch_y,
   input  logic signed [31:0]                        req_stretch_z,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic signed [31:0]                        rsp_stress_x,
   input  logic signed [31:0]                        rsp_stress_y,
   input  logic signed [31:0]                        rsp_stress_z,
   input  logic signed [31:0]                        rsp_energy,
   input  logic                                      csr_write,
   input  logic [svk_pse_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [svk_pse_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int DEPTH = 8;

   logic [3:0] occupancy_ff;
   logic [3:0] occupancy_in;
   logic [1:0] dimensions_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;

   always_comb begin
      occupancy_in = occupancy_ff;
      if (req_beat && !rsp_beat) begin
         occupancy_in = occupancy_ff + 4'd1;
      end else if (rsp_beat && !req_beat) begin
         occupancy_in = occupancy_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff  <= '0;
         dimensions_ff <= svk_pse_pkg::DIMENSIONS_RESET;
      end else begin
         occupancy_ff <= occupancy_in;
         if (csr_write && csr_index == svk_pse_pkg::CSR_DIMENSIONS) begin
            dimensions_ff <= csr_data[1:0];
         end
      end
   end

   // a held request beat keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_stretch_x)
         && $stable(req_stretch_y) && $stable(req_stretch_z))
      else $error("request beat changed while stalled");

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stress_x)
         && $stable(rsp_stress_y) && $stable(rsp_stress_z) && $stable(rsp_energy))
      else $error("result beat changed while stalled");

   // no result beat without a request beat in flight
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occupancy_ff != 4'd0)
      else $error("result beat with nothing in flight");

   // never more beats in flight than pipeline stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= 4'(DEPTH))
      else $error("more beats in flight than pipeline stages");

   // planar mode leaves the third axis unloaded
   a_planar_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dimensions_ff == svk_pse_pkg::DIMENSIONS_PLANAR |-> rsp_stress_z == '0)
      else $error("third axis stress non-zero in planar mode");

endmodule

bind svk_principal_stress_energy_unit svk_pse_checker u_checker (.*);

// ===== tb/sv/svk_principal_stress_energy_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svk_principal_stress_energy_unit_tb
// self-checking bench for the principal stress and strain energy unit
// ---------------------------------------------------------------------------
// A queue of stretch triples is filled phase by phase. A clocked driver sends
// them in bursts with random gaps. Every accepted beat is predicted in 64-bit
// fixed point from a shadow copy of the material registers. A clocked monitor
// stalls the result side on changing patterns and checks each result beat
// field by field against the oldest prediction. Registers are rewritten only
// once the pipeline has drained. The settings include planar mode, floors
// above one, zero and full-scale moduli and a negative lambda.
// ---------------------------------------------------------------------------
module svk_principal_stress_energy_unit_tb;

   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 95;
   localparam int SETTLE_CYCLES    = 12;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } stretch_set_type;

   typedef struct packed {
      logic signed [31:0] stress_x;
      logic signed [31:0] stress_y;
      logic signed [31:0] stress_z;
      logic signed [31:0] energy;
   } principal_result_type;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // clock, reset and every block input start at known values
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [31:0]  req_stretch_x = '0;
   logic signed [31:0]  req_stretch_y = '0;
   logic signed [31:0]  req_stretch_z = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_stress_x;
   logic signed [31:0]  rsp_stress_y;
   logic signed [31:0]  rsp_stress_z;
   logic signed [31:0]  rsp_energy;
   logic                csr_write = 1'b0;
   logic [svk_pse_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [svk_pse_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // shadow of the material registers as the block should hold them
   logic [1:0]          dim_q    = svk_pse_pkg::DIMENSIONS_RESET;
   logic [16:0]         floor_q  = svk_pse_pkg::CLAMP_FLOOR_RESET;
   logic [30:0]         mu_q     = svk_pse_pkg::SHEAR_MOD_RESET;
   logic signed [31:0]  lambda_q = svk_pse_pkg::LAME_LAMBDA_RESET;

   stretch_set_type       pending_stretches [$];
   principal_result_type  expected_results [$];
   stretch_set_type       req_item;
   principal_result_type  want_result;
   int                    error_count = 0;
   int                    burst_left = 8;
   int                    gap_left = 0;
   int                    stall_window = 0;
   stall_mode_type        stall_mode = STALL_NONE;

   svk_principal_stress_energy_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_stretch_x (req_stretch_x),
      .req_stretch_y (req_stretch_y),
      .req_stretch_z (req_stretch_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_stress_x  (rsp_stress_x),
      .rsp_stress_y  (rsp_stress_y),
      .rsp_stress_z  (rsp_stress_z),
      .rsp_energy    (rsp_energy),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 4 ns period, first rising edge at 2 ns
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // clip a wide intermediate to the signed 32-bit word range
   function automatic logic signed [63:0] clip_to_word(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // diagonal piola-kirchhoff stress and energy density for one element;
   // arithmetic right shifts on signed values give the floor division
   function automatic principal_result_type predict_stress_energy(input stretch_set_type item);
      logic signed [63:0] s [3];
      logic signed [63:0] g [3];
      logic signed [63:0] stress [3];
      logic signed [31:0] raw [3];
      logic signed [63:0] mu;
      logic signed [63:0] lam;
      logic signed [63:0] lower;
      logic signed [63:0] tr;
      logic signed [63:0] h;
      logic signed [63:0] u;
      logic signed [63:0] p;
      logic signed [63:0] q;
      logic signed [63:0] e;
      int                 axes;
      principal_result_type r;
      mu    = $signed({33'd0, mu_q});
      lam   = lambda_q;
      lower = $signed({47'd0, floor_q});
      axes  = (dim_q == svk_pse_pkg::DIMENSIONS_PLANAR) ? 2 : 3;
      raw[0] = item.x;
      raw[1] = item.y;
      raw[2] = item.z;
      // clamp from below, then green strain per active axis
      for (int i = 0; i < 3; i++) begin
         s[i] = raw[i];
         if (s[i] < lower) s[i] = lower;
         if (i < axes) begin
            g[i] = clip_to_word(((s[i] * s[i]) >>> 16) - 64'sd65536);
         end else begin
            g[i] = 64'sd0;
         end
      end
      tr = clip_to_word(g[0] + g[1] + g[2]);
      h  = (lam * tr) >>> 17;
      p  = 64'sd0;
      for (int i = 0; i < 3; i++) begin
         stress[i] = 64'sd0;
         if (i < axes) begin
            u = clip_to_word(((mu * g[i]) >>> 16) + h);
            stress[i] = clip_to_word((s[i] * u) >>> 16);
         end
         p = p + clip_to_word((g[i] * g[i]) >>> 16);
      end
      p = clip_to_word(p);
      q = clip_to_word((tr * tr) >>> 16);
      e = clip_to_word(((lam * q) >>> 19) + ((mu * p) >>> 18));
      r.stress_x = stress[0][31:0];
      r.stress_y = stress[1][31:0];
      r.stress_z = stress[2][31:0];
      r.energy   = e[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // one register write, mirrored into the shadow with the block's masking
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         svk_pse_pkg::CSR_DIMENSIONS:  dim_q    = data[1:0];
         svk_pse_pkg::CSR_CLAMP_FLOOR: floor_q  = data[16:0];
         svk_pse_pkg::CSR_SHEAR_MOD:   mu_q     = data[30:0];
         svk_pse_pkg::CSR_LAME_LAMBDA: lambda_q = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_stretches(input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z);
      stretch_set_type item;
      item.x = x;
      item.y = y;
      item.z = z;
      pending_stretches.push_back(item);
   endtask

   // sampled on the falling edge so the driver's queue pop and valid update
   // have both settled
   task automatic wait_for_drain();
      while (pending_stretches.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stretches biased towards the interesting regions: near rest length,
   // around the floor, compressed or inverted, huge, and the word extremes
   function automatic logic signed [31:0] random_stretch();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 32'sd65536 + $signed($urandom_range(0, 80000)) - 32'sd40000;
         4:          v = $signed({15'd0, floor_q}) + $signed($urandom_range(0, 8)) - 32'sd4;
         5:          v = $signed($urandom_range(0, 200000)) - 32'sd100000;
         6, 7:       v = $urandom();
         8:          v = $urandom_range(32'h0010_0000, 32'h7fff_ffff);
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = 32'sd0;
               default: v = 32'sd65536;
            endcase
         end
      endcase
      return v;
   endfunction

   // fresh material for a random phase; unused upper bits carry junk
   task automatic randomise_material();
      logic [31:0] word;
      word = $urandom();
      word[1:0] = 2'($urandom_range(0, 3));
      write_csr(svk_pse_pkg::CSR_DIMENSIONS, word);
      word = $urandom();
      case ($urandom_range(0, 4))
         0:       word[16:0] = 17'd0;
         1:       word[16:0] = 17'd65536;
         2:       word[16:0] = 17'h1ffff;
         default: word[16:0] = 17'($urandom_range(20000, 70000));
      endcase
      write_csr(svk_pse_pkg::CSR_CLAMP_FLOOR, word);
      word = $urandom();
      case ($urandom_range(0, 5))
         0:       word[30:0] = 31'd0;
         1:       word[30:0] = 31'h7fff_ffff;
         2:       ;
         default: word[30:0] = 31'($urandom_range(0, 32'h0010_0000));
      endcase
      write_csr(svk_pse_pkg::CSR_SHEAR_MOD, word);
      case ($urandom_range(0, 6))
         0:       word = 32'h8000_0000;
         1:       word = 32'h7fff_ffff;
         2:       word = 32'h0000_0000;
         3:       word = $urandom();
         default: word = $unsigned($signed($urandom_range(0, 32'h0020_0000)) - 32'sd1048576);
      endcase
      write_csr(svk_pse_pkg::CSR_LAME_LAMBDA, word);
   endtask

   // request driver: bursts of random length separated by random gaps; a
   // stalled beat is held unchanged until it goes through
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_stress_energy(req_item));
         end
         if (req_valid && req_stall) begin
            // hold the current beat
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_stretches.size() != 0) begin
            req_item = pending_stretches.pop_front();
            req_stretch_x <= req_item.x;
            req_stretch_y <= req_item.y;
            req_stretch_z <= req_item.z;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               // a quarter of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor: checks each accepted beat against the oldest prediction
   // and drives the stall from a pattern that is redrawn after each random window
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing outstanding, energy", rsp_energy,
                               32'd0);
            end else begin
               want_result = expected_results.pop_front();
               if (rsp_stress_x !== want_result.stress_x)
                  report_mismatch("stress_x", rsp_stress_x, want_result.stress_x);
               if (rsp_stress_y !== want_result.stress_y)
                  report_mismatch("stress_y", rsp_stress_y, want_result.stress_y);
               if (rsp_stress_z !== want_result.stress_z)
                  report_mismatch("stress_z", rsp_stress_z, want_result.stress_z);
               if (rsp_energy !== want_result.energy)
                  report_mismatch("energy", rsp_energy, want_result.energy);
            end
         end
         if (stall_window <= 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 3));
            stall_window = $urandom_range(20, 120);
         end
         stall_window--;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= ((stall_window % 5) < 2);
            default:        rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   // stimulus and end of run
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset material: rest length, clamped, at the floor and saturating
      @(negedge clock);
      add_stretches(32'sd65536, 32'sd65536, 32'sd65536);
      add_stretches(32'sd0, 32'sd0, 32'sd0);
      add_stretches(32'sh8000_0000, -32'sd1, 32'sd37836);
      add_stretches(32'sd37837, 32'sd37838, 32'sd37837);
      add_stretches(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      add_stretches(32'sd131072, 32'sd65536, 32'sd32768);
      add_stretches(32'sh0000_ffff, 32'sh0001_0001, 32'sh5555_5555);
      add_stretches(32'shaaaa_aaaa, 32'sh7fff_0000, 32'sh0008_0000);
      wait_for_drain();

      // planar, zero floor, full-scale mu, most negative lambda
      write_csr(svk_pse_pkg::CSR_DIMENSIONS, 32'hffff_fffe);
      write_csr(svk_pse_pkg::CSR_CLAMP_FLOOR, 32'hfffe_0000);
      write_csr(svk_pse_pkg::CSR_SHEAR_MOD, 32'hffff_ffff);
      write_csr(svk_pse_pkg::CSR_LAME_LAMBDA, 32'h8000_0000);
      @(negedge clock);
      add_stretches(32'sd65536, 32'sd65536, 32'sh7fff_ffff);
      add_stretches(32'sd0, 32'sd0, 32'sh8000_0000);
      add_stretches(32'sh7fff_ffff, 32'sd0, 32'sd65536);
      add_stretches(-32'sd1, -32'sd1, -32'sd1);
      add_stretches(32'sd40000, 32'sd90000, 32'sd12345);
      wait_for_drain();

      // dimensions zero still means three axes; floor above one, mu zero
      write_csr(svk_pse_pkg::CSR_DIMENSIONS, 32'h0000_0000);
      write_csr(svk_pse_pkg::CSR_CLAMP_FLOOR, 32'h0001_ffff);
      write_csr(svk_pse_pkg::CSR_SHEAR_MOD, 32'h0000_0000);
      write_csr(svk_pse_pkg::CSR_LAME_LAMBDA, 32'h7fff_ffff);
      @(negedge clock);
      add_stretches(32'sd65536, 32'sd65536, 32'sd65536);
      add_stretches(32'sd200000, -32'sd5, 32'sh7fff_ffff);
      add_stretches(32'sd131071, 32'sd131072, 32'sd131070);
      wait_for_drain();

      // dimensions one, floor at exactly one, negative poisson material
      write_csr(svk_pse_pkg::CSR_DIMENSIONS, 32'h0000_0001);
      write_csr(svk_pse_pkg::CSR_CLAMP_FLOOR, 32'h0001_0000);
      write_csr(svk_pse_pkg::CSR_SHEAR_MOD, 32'h0003_0000);
      write_csr(svk_pse_pkg::CSR_LAME_LAMBDA, 32'hffff_0000);
      @(negedge clock);
      add_stretches(32'sd70000, 32'sd60000, 32'sd65536);
      add_stretches(32'sh7fff_ffff, 32'sd98304, 32'sh8000_0000);
      add_stretches(32'sd65535, 32'sd65537, 32'sd81920);
      wait_for_drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         randomise_material();
         @(negedge clock);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            add_stretches(random_stretch(), random_stretch(), random_stretch());
         end
         wait_for_drain();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
